/* rtl/lsad_pkg.sv */
// shared types and constants for the load/store address decode unit
`default_nettype none

package lsad_pkg;

  // cache block size in bytes, a power of two
  localparam int unsigned CACHE_LINE_BYTES = 128;
  localparam logic [63:0] LINE_MASK = ~(64'(CACHE_LINE_BYTES) - 64'd1);
  localparam logic [7:0]  LINE_BYTES = 8'(CACHE_LINE_BYTES);

  // cap for length-in-register vector forms
  localparam logic [7:0] LEN_CAP = 8'd16;

  // primary opcodes
  localparam logic [5:0] OP_X31   = 6'd31;
  localparam logic [5:0] OP_LWZ   = 6'd32;
  localparam logic [5:0] OP_LWZU  = 6'd33;
  localparam logic [5:0] OP_LBZ   = 6'd34;
  localparam logic [5:0] OP_LBZU  = 6'd35;
  localparam logic [5:0] OP_STW   = 6'd36;
  localparam logic [5:0] OP_STWU  = 6'd37;
  localparam logic [5:0] OP_STB   = 6'd38;
  localparam logic [5:0] OP_STBU  = 6'd39;
  localparam logic [5:0] OP_LHZ   = 6'd40;
  localparam logic [5:0] OP_LHZU  = 6'd41;
  localparam logic [5:0] OP_LHA   = 6'd42;
  localparam logic [5:0] OP_LHAU  = 6'd43;
  localparam logic [5:0] OP_STH   = 6'd44;
  localparam logic [5:0] OP_STHU  = 6'd45;
  localparam logic [5:0] OP_LMW   = 6'd46;
  localparam logic [5:0] OP_STMW  = 6'd47;
  localparam logic [5:0] OP_LFS   = 6'd48;
  localparam logic [5:0] OP_LFSU  = 6'd49;
  localparam logic [5:0] OP_LFD   = 6'd50;
  localparam logic [5:0] OP_LFDU  = 6'd51;
  localparam logic [5:0] OP_STFS  = 6'd52;
  localparam logic [5:0] OP_STFSU = 6'd53;
  localparam logic [5:0] OP_STFD  = 6'd54;
  localparam logic [5:0] OP_STFDU = 6'd55;
  localparam logic [5:0] OP_LQ    = 6'd56;
  localparam logic [5:0] OP_DS57  = 6'd57;
  localparam logic [5:0] OP_DS58  = 6'd58;
  localparam logic [5:0] OP_DQ61  = 6'd61;
  localparam logic [5:0] OP_DS62  = 6'd62;

  // what gets added to the base register
  typedef enum logic [2:0] {
    ADD_D    = 3'd0,
    ADD_DS   = 3'd1,
    ADD_DQ   = 3'd2,
    ADD_RB   = 3'd3,
    ADD_ZERO = 3'd4
  } add_sel_t;

  // low address bits cleared after the add
  typedef enum logic [2:0] {
    MASK_NONE = 3'd0,
    MASK_2    = 3'd1,
    MASK_4    = 3'd2,
    MASK_16   = 3'd3,
    MASK_LINE = 3'd4
  } mask_sel_t;

  // decode result handed to the address generator
  typedef struct packed {
    logic       is_access;
    logic       unsupported;
    logic       len_form;
    logic       multiple;
    add_sel_t   add_sel;
    mask_sel_t  mask_sel;
    logic [7:0] bytes;
  } dec_t;

endpackage

`default_nettype wire

/* rtl/lsad_decode.sv */
// instruction classification: access form, size, addend and alignment
`default_nettype none

module lsad_decode (
  input  wire logic [31:0]   instruction,
  output lsad_pkg::dec_t     dec
);

  logic [5:0] opc;
  logic [9:0] xo;
  logic [1:0] s2;
  logic [2:0] s3;

  assign opc = instruction[31:26];
  assign xo  = instruction[10:1];
  assign s2  = instruction[1:0];
  assign s3  = instruction[2:0];

  always_comb begin
    dec             = '0;
    dec.add_sel     = lsad_pkg::ADD_D;
    dec.mask_sel    = lsad_pkg::MASK_NONE;
    case (opc)
      // indexed forms, classified by extended opcode
      lsad_pkg::OP_X31: begin
        dec.add_sel   = lsad_pkg::ADD_RB;
        dec.is_access = 1'b1;
        case (xo)
          // byte accesses
          7, 135, 781, 909, 52, 694, 87, 119, 215, 247, 853, 981:
            dec.bytes = 8'd1;
          // vector element halfword
          39, 167: begin
            dec.bytes    = 8'd2;
            dec.mask_sel = lsad_pkg::MASK_2;
          end
          // vector element word
          71, 199: begin
            dec.bytes    = 8'd4;
            dec.mask_sel = lsad_pkg::MASK_4;
          end
          // full vector, quadword aligned
          103, 231, 359, 487: begin
            dec.bytes    = 8'd16;
            dec.mask_sel = lsad_pkg::MASK_16;
          end
          // length taken from the index register
          269, 301, 397, 429: begin
            dec.len_form = 1'b1;
            dec.add_sel  = lsad_pkg::ADD_ZERO;
          end
          // halfword accesses
          813, 941, 116, 726, 279, 311, 343, 375, 407, 439, 790, 918, 821, 949:
            dec.bytes = 8'd2;
          // word accesses
          12, 76, 140, 364, 524, 652, 20, 150, 23, 151, 55, 341, 373, 183,
          534, 662, 789, 917, 535, 567, 663, 695, 855, 887, 983:
            dec.bytes = 8'd4;
          // doubleword accesses
          332, 588, 716, 84, 214, 21, 149, 53, 181, 532, 660, 885, 1013,
          309, 599, 631, 727, 759:
            dec.bytes = 8'd8;
          // quadword accesses
          268, 396, 780, 908, 812, 940, 844, 972, 876, 1004, 276, 182, 791, 919:
            dec.bytes = 8'd16;
          // cache block ops, block aligned
          22, 54, 86, 246, 278, 982, 1014: begin
            dec.bytes    = lsad_pkg::LINE_BYTES;
            dec.mask_sel = lsad_pkg::MASK_LINE;
          end
          // cache block copy and paste, unaligned
          774, 902:
            dec.bytes = lsad_pkg::LINE_BYTES;
          // string and atomic memory forms
          533, 661, 597, 725, 582, 710, 614, 742: begin
            dec.is_access   = 1'b0;
            dec.unsupported = 1'b1;
          end
          default:
            dec.is_access = 1'b0;
        endcase
      end
      // DS form, vector scalar loads
      lsad_pkg::OP_DS57: begin
        dec.add_sel = lsad_pkg::ADD_DS;
        case (s2)
          2'd0: begin dec.bytes = 8'd16; dec.is_access = 1'b1; end
          2'd2: begin dec.bytes = 8'd8;  dec.is_access = 1'b1; end
          2'd3: begin dec.bytes = 8'd4;  dec.is_access = 1'b1; end
          default: dec.is_access = 1'b0;
        endcase
      end
      // DS form, doubleword and word loads
      lsad_pkg::OP_DS58: begin
        dec.add_sel = lsad_pkg::ADD_DS;
        if (s2 inside {2'd0, 2'd1}) begin
          dec.bytes     = 8'd8;
          dec.is_access = 1'b1;
        end else if (s2 == 2'd2) begin
          dec.bytes     = 8'd4;
          dec.is_access = 1'b1;
        end
      end
      // DQ and DS forms, vector scalar stores
      lsad_pkg::OP_DQ61: begin
        dec.is_access = 1'b1;
        if (s3 inside {3'd1, 3'd5}) begin
          dec.add_sel = lsad_pkg::ADD_DQ;
          dec.bytes   = 8'd16;
        end else begin
          dec.add_sel = lsad_pkg::ADD_DS;
          case (s3[1:0])
            2'd0:    dec.bytes = 8'd16;
            2'd2:    dec.bytes = 8'd8;
            default: dec.bytes = 8'd4;
          endcase
        end
      end
      // DS form, doubleword and quadword stores
      lsad_pkg::OP_DS62: begin
        dec.add_sel = lsad_pkg::ADD_DS;
        if (s2 inside {2'd0, 2'd1}) begin
          dec.bytes     = 8'd8;
          dec.is_access = 1'b1;
        end else if (s2 == 2'd2) begin
          dec.bytes     = 8'd16;
          dec.is_access = 1'b1;
        end
      end
      // D form words and floats
      lsad_pkg::OP_LWZ, lsad_pkg::OP_LWZU, lsad_pkg::OP_STW, lsad_pkg::OP_STWU,
      lsad_pkg::OP_LFS, lsad_pkg::OP_LFSU, lsad_pkg::OP_STFS, lsad_pkg::OP_STFSU: begin
        dec.bytes     = 8'd4;
        dec.is_access = 1'b1;
      end
      // D form bytes
      lsad_pkg::OP_LBZ, lsad_pkg::OP_LBZU, lsad_pkg::OP_STB, lsad_pkg::OP_STBU: begin
        dec.bytes     = 8'd1;
        dec.is_access = 1'b1;
      end
      // D form halfwords
      lsad_pkg::OP_LHZ, lsad_pkg::OP_LHZU, lsad_pkg::OP_LHA, lsad_pkg::OP_LHAU,
      lsad_pkg::OP_STH, lsad_pkg::OP_STHU: begin
        dec.bytes     = 8'd2;
        dec.is_access = 1'b1;
      end
      // D form doubles
      lsad_pkg::OP_LFD, lsad_pkg::OP_LFDU, lsad_pkg::OP_STFD, lsad_pkg::OP_STFDU: begin
        dec.bytes     = 8'd8;
        dec.is_access = 1'b1;
      end
      // DQ form quadword load
      lsad_pkg::OP_LQ: begin
        dec.add_sel   = lsad_pkg::ADD_DQ;
        dec.bytes     = 8'd16;
        dec.is_access = 1'b1;
      end
      // load and store multiple, size follows RT
      lsad_pkg::OP_LMW, lsad_pkg::OP_STMW: begin
        dec.multiple  = 1'b1;
        dec.is_access = 1'b1;
      end
      default: dec.is_access = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lsad_agen.sv */
// effective address adder, alignment and final size selection
`default_nettype none

module lsad_agen (
  input  wire logic [31:0]    instruction,
  input  wire logic [63:0]    base_value,
  input  wire logic [63:0]    index_value,
  input  wire lsad_pkg::dec_t dec,
  output logic [63:0]         effective_address,
  output logic [7:0]          access_bytes
);

  logic [63:0] base;
  logic [63:0] addend;
  logic [63:0] sum;
  logic [63:0] mask;
  logic [7:0]  len_bytes;
  logic [7:0]  mult_bytes;
  logic [7:0]  bytes;

  // base register reads as zero when the RA field is zero
  assign base = (instruction[20:16] != 5'd0) ? base_value : 64'd0;

  // sign-extended displacement, index register or zero
  always_comb begin
    case (dec.add_sel)
      lsad_pkg::ADD_D:    addend = {{48{instruction[15]}}, instruction[15:0]};
      lsad_pkg::ADD_DS:   addend = {{48{instruction[15]}}, instruction[15:2], 2'b00};
      lsad_pkg::ADD_DQ:   addend = {{48{instruction[15]}}, instruction[15:4], 4'b0000};
      lsad_pkg::ADD_RB:   addend = index_value;
      default:            addend = 64'd0;
    endcase
  end

  assign sum = base + addend;

  // clear low bits for element, full vector and cache block forms
  always_comb begin
    case (dec.mask_sel)
      lsad_pkg::MASK_2:    mask = ~64'h1;
      lsad_pkg::MASK_4:    mask = ~64'h3;
      lsad_pkg::MASK_16:   mask = ~64'hf;
      lsad_pkg::MASK_LINE: mask = lsad_pkg::LINE_MASK;
      default:             mask = '1;
    endcase
  end

  // length from the top byte of RB, capped; multiple is four bytes per register
  assign len_bytes  = (index_value[63:56] > lsad_pkg::LEN_CAP) ?
                      lsad_pkg::LEN_CAP : index_value[63:56];
  assign mult_bytes = {6'd32 - {1'b0, instruction[25:21]}, 2'b00};

  always_comb begin
    if (dec.len_form) begin
      bytes = len_bytes;
    end else if (dec.multiple) begin
      bytes = mult_bytes;
    end else begin
      bytes = dec.bytes;
    end
  end

  // non-accesses report zero address and size
  assign effective_address = dec.is_access ? (sum & mask) : 64'd0;
  assign access_bytes      = dec.is_access ? bytes : 8'd0;

endmodule

`default_nettype wire

/* rtl/load_store_address_decode_unit.sv */
// top level: request register, decode and address generation, result register
// a request is held in the request register, and its result becomes valid in the result register
// throughput: one request per cycle while the output is not stalled; decode and the 64-bit address add sit
//   between the two register stages
// a request is still taken while a finished result waits on a stalled output, if the request register is empty
// reset: synchronous active-low rst_n clears both stage valid bits; no other state
`default_nettype none

module load_store_address_decode_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instruction,
  input  wire logic [63:0] in_base_value,
  input  wire logic [63:0] in_index_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_access,
  output logic             out_unsupported,
  output logic [63:0]      out_effective_address,
  output logic [7:0]       out_access_bytes
);

  logic           s1_valid_r;
  logic [31:0]    s1_instr_r;
  logic [63:0]    s1_base_r;
  logic [63:0]    s1_index_r;
  logic           out_valid_r;
  logic           out_is_access_r;
  logic           out_unsupported_r;
  logic [63:0]    out_ea_r;
  logic [7:0]     out_bytes_r;
  logic           s1_valid_nxt;
  logic           out_valid_nxt;
  logic           out_adv;
  logic           in_take;
  lsad_pkg::dec_t dec;
  logic [63:0]    ea;
  logic [7:0]     bytes;

  // result register can load when empty or being drained
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_adv);
  assign out_valid_nxt = (s1_valid_r && out_adv) || (out_valid_r && out_stall);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_instr_r <= in_instruction;
      s1_base_r  <= in_base_value;
      s1_index_r <= in_index_value;
    end
  end

  lsad_decode u_decode (
    .instruction (s1_instr_r),
    .dec         (dec)
  );

  lsad_agen u_agen (
    .instruction       (s1_instr_r),
    .base_value        (s1_base_r),
    .index_value       (s1_index_r),
    .dec               (dec),
    .effective_address (ea),
    .access_bytes      (bytes)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_valid_r && out_adv) begin
      out_is_access_r   <= dec.is_access;
      out_unsupported_r <= dec.unsupported;
      out_ea_r          <= ea;
      out_bytes_r       <= bytes;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_is_access         = out_is_access_r;
  assign out_unsupported       = out_unsupported_r;
  assign out_effective_address = out_ea_r;
  assign out_access_bytes      = out_bytes_r;

  // unsupported forms are never reported as accesses
  a_unsup_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_access_r && out_unsupported_r))
    else $error("unsupported form reported as access");

  // non-accesses carry zero address and size
  a_zero_non_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_access_r) |-> (out_ea_r == 64'd0 && out_bytes_r == 8'd0))
    else $error("non-access result has nonzero address or size");

  // input only stalls when a request is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty request register");

  // a request leaving the first stage lands in the result register
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("request lost between stages");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// testbench for the load/store address decode unit: directed and random requests checked in order
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam logic [7:0] LEN_LIMIT = 8'd16;

  // opcode with no storage access and an X-form sub-opcode that is not a load/store
  localparam logic [5:0] OP_ILLEGAL = 6'd0;
  localparam logic [9:0] XO_CMP = 10'd0;

  // DS/DQ form selectors in the low instruction bits
  localparam logic [1:0] DS57_LFDP = 2'd0;
  localparam logic [1:0] DS57_RSVD = 2'd1;
  localparam logic [1:0] DS57_LXSD = 2'd2;
  localparam logic [1:0] DS57_LXSSP = 2'd3;
  localparam logic [1:0] DS58_LD = 2'd0;
  localparam logic [1:0] DS58_LDU = 2'd1;
  localparam logic [1:0] DS58_LWA = 2'd2;
  localparam logic [1:0] DS58_RSVD = 2'd3;
  localparam logic [1:0] DS62_STD = 2'd0;
  localparam logic [1:0] DS62_STDU = 2'd1;
  localparam logic [1:0] DS62_STQ = 2'd2;
  localparam logic [1:0] DS62_RSVD = 2'd3;
  localparam logic [2:0] DQ61_LXV = 3'd1;
  localparam logic [2:0] DQ61_STXV = 3'd5;
  localparam logic [1:0] SEL61_STFDP = 2'd0;
  localparam logic [1:0] SEL61_STXSD = 2'd2;

  // opcode-31 sub-opcodes grouped by how the address and size come out
  localparam logic [9:0] XO_B1 [12] = '{7, 135, 781, 909, 52, 694, 87, 119, 215, 247, 853, 981};
  localparam logic [9:0] XO_B2 [14] = '{813, 941, 116, 726, 279, 311, 343, 375, 407, 439,
                                        790, 918, 821, 949};
  localparam logic [9:0] XO_B4 [25] = '{12, 76, 140, 364, 524, 652, 20, 150, 23, 151, 55, 341,
                                        373, 183, 534, 662, 789, 917, 535, 567, 663, 695, 855,
                                        887, 983};
  localparam logic [9:0] XO_B8 [18] = '{332, 588, 716, 84, 214, 21, 149, 53, 181, 532, 660, 885,
                                        1013, 309, 599, 631, 727, 759};
  localparam logic [9:0] XO_B16 [14] = '{268, 396, 780, 908, 812, 940, 844, 972, 876, 1004,
                                         276, 182, 791, 919};
  localparam logic [9:0] XO_MASK2 [2] = '{39, 167};
  localparam logic [9:0] XO_MASK4 [2] = '{71, 199};
  localparam logic [9:0] XO_MASK16 [4] = '{103, 231, 359, 487};
  localparam logic [9:0] XO_LEN [4] = '{269, 301, 397, 429};
  localparam logic [9:0] XO_LINE [7] = '{22, 54, 86, 246, 278, 982, 1014};
  localparam logic [9:0] XO_LINE_PLAIN [2] = '{774, 902};
  localparam logic [9:0] XO_UNSUP [8] = '{533, 661, 597, 725, 582, 710, 614, 742};

  // primary opcodes that are storage accesses or may be
  localparam logic [5:0] MEM_OPS [29] = '{
    lsad_pkg::OP_LWZ, lsad_pkg::OP_LWZU, lsad_pkg::OP_LBZ, lsad_pkg::OP_LBZU,
    lsad_pkg::OP_STW, lsad_pkg::OP_STWU, lsad_pkg::OP_STB, lsad_pkg::OP_STBU,
    lsad_pkg::OP_LHZ, lsad_pkg::OP_LHZU, lsad_pkg::OP_LHA, lsad_pkg::OP_LHAU,
    lsad_pkg::OP_STH, lsad_pkg::OP_STHU, lsad_pkg::OP_LMW, lsad_pkg::OP_STMW,
    lsad_pkg::OP_LFS, lsad_pkg::OP_LFSU, lsad_pkg::OP_LFD, lsad_pkg::OP_LFDU,
    lsad_pkg::OP_STFS, lsad_pkg::OP_STFSU, lsad_pkg::OP_STFD, lsad_pkg::OP_STFDU,
    lsad_pkg::OP_LQ, lsad_pkg::OP_DS57, lsad_pkg::OP_DS58, lsad_pkg::OP_DQ61,
    lsad_pkg::OP_DS62};

  typedef enum logic [2:0] {
    XK_NONE,
    XK_PLAIN,
    XK_MASK,
    XK_LEN,
    XK_UNSUP
  } xo_kind_t;

  typedef struct packed {
    logic        is_access;
    logic        unsupported;
    logic [63:0] ea;
    logic [7:0]  nbytes;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction = '0;
  logic [63:0] in_base_value = '0;
  logic [63:0] in_index_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_access;
  logic        out_unsupported;
  logic [63:0] out_effective_address;
  logic [7:0]  out_access_bytes;

  xo_kind_t    xo_kind [1024];
  logic [7:0]  xo_size [1024];
  logic [9:0]  known_xo [$];
  access_t     pending_accesses [$];
  int          error_count = 0;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 28;
  int          stall_hold = 0;
  int          quiet_cycles = 0;

  load_store_address_decode_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_instruction        (in_instruction),
    .in_base_value         (in_base_value),
    .in_index_value        (in_index_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_is_access         (out_is_access),
    .out_unsupported       (out_unsupported),
    .out_effective_address (out_effective_address),
    .out_access_bytes      (out_access_bytes)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_xo(input logic [9:0] code, input xo_kind_t kind,
                                  input logic [7:0] size);
    xo_kind[code] = kind;
    xo_size[code] = size;
    known_xo.push_back(code);
  endfunction

  // sub-opcode lookup used by the predictor and the stimulus
  function automatic void build_xo_tables();
    foreach (xo_kind[i]) begin
      xo_kind[i] = XK_NONE;
      xo_size[i] = 8'd0;
    end
    foreach (XO_B1[i]) note_xo(XO_B1[i], XK_PLAIN, 8'd1);
    foreach (XO_B2[i]) note_xo(XO_B2[i], XK_PLAIN, 8'd2);
    foreach (XO_B4[i]) note_xo(XO_B4[i], XK_PLAIN, 8'd4);
    foreach (XO_B8[i]) note_xo(XO_B8[i], XK_PLAIN, 8'd8);
    foreach (XO_B16[i]) note_xo(XO_B16[i], XK_PLAIN, 8'd16);
    foreach (XO_MASK2[i]) note_xo(XO_MASK2[i], XK_MASK, 8'd2);
    foreach (XO_MASK4[i]) note_xo(XO_MASK4[i], XK_MASK, 8'd4);
    foreach (XO_MASK16[i]) note_xo(XO_MASK16[i], XK_MASK, 8'd16);
    foreach (XO_LEN[i]) note_xo(XO_LEN[i], XK_LEN, 8'd0);
    foreach (XO_LINE[i]) note_xo(XO_LINE[i], XK_MASK, 8'(lsad_pkg::CACHE_LINE_BYTES));
    foreach (XO_LINE_PLAIN[i]) begin
      note_xo(XO_LINE_PLAIN[i], XK_PLAIN, 8'(lsad_pkg::CACHE_LINE_BYTES));
    end
    foreach (XO_UNSUP[i]) note_xo(XO_UNSUP[i], XK_UNSUP, 8'd0);
  endfunction

  // expected effective address and size for one instruction
  function automatic access_t decode_access(input logic [31:0] w, input logic [63:0] base_in,
                                            input logic [63:0] index_in);
    access_t     r;
    logic [63:0] b;
    logic [63:0] d16;
    logic [63:0] ds;
    logic [63:0] dq;
    logic [9:0]  xo;
    logic [7:0]  len;
    int          rt;
    r = '0;
    b = (w[20:16] != 5'd0) ? base_in : 64'd0;
    d16 = {{48{w[15]}}, w[15:0]};
    ds = {{48{w[15]}}, w[15:2], 2'b00};
    dq = {{48{w[15]}}, w[15:4], 4'b0000};
    xo = w[10:1];
    rt = int'(w[25:21]);
    case (w[31:26])
      lsad_pkg::OP_X31: begin
        case (xo_kind[xo])
          XK_PLAIN: begin
            r.is_access = 1'b1;
            r.ea = b + index_in;
            r.nbytes = xo_size[xo];
          end
          XK_MASK: begin
            r.is_access = 1'b1;
            r.ea = (b + index_in) & ~(64'(xo_size[xo]) - 64'd1);
            r.nbytes = xo_size[xo];
          end
          XK_LEN: begin
            // length from the top byte of RB, RB itself not added
            len = index_in[63:56];
            r.is_access = 1'b1;
            r.ea = b;
            r.nbytes = (len > LEN_LIMIT) ? LEN_LIMIT : len;
          end
          XK_UNSUP: r.unsupported = 1'b1;
          default: ;
        endcase
      end
      lsad_pkg::OP_DS57: begin
        r.ea = b + ds;
        case (w[1:0])
          DS57_LFDP: begin r.is_access = 1'b1; r.nbytes = 8'd16; end
          DS57_LXSD: begin r.is_access = 1'b1; r.nbytes = 8'd8; end
          DS57_LXSSP: begin r.is_access = 1'b1; r.nbytes = 8'd4; end
          default: ;
        endcase
      end
      lsad_pkg::OP_DS58: begin
        r.ea = b + ds;
        case (w[1:0])
          DS58_LD, DS58_LDU: begin r.is_access = 1'b1; r.nbytes = 8'd8; end
          DS58_LWA: begin r.is_access = 1'b1; r.nbytes = 8'd4; end
          default: ;
        endcase
      end
      lsad_pkg::OP_DQ61: begin
        r.is_access = 1'b1;
        if (w[2:0] == DQ61_LXV || w[2:0] == DQ61_STXV) begin
          r.ea = b + dq;
          r.nbytes = 8'd16;
        end else begin
          r.ea = b + ds;
          if (w[1:0] == SEL61_STFDP) r.nbytes = 8'd16;
          else if (w[1:0] == SEL61_STXSD) r.nbytes = 8'd8;
          else r.nbytes = 8'd4;
        end
      end
      lsad_pkg::OP_DS62: begin
        r.ea = b + ds;
        case (w[1:0])
          DS62_STD, DS62_STDU: begin r.is_access = 1'b1; r.nbytes = 8'd8; end
          DS62_STQ: begin r.is_access = 1'b1; r.nbytes = 8'd16; end
          default: ;
        endcase
      end
      lsad_pkg::OP_LWZ, lsad_pkg::OP_LWZU, lsad_pkg::OP_STW, lsad_pkg::OP_STWU,
      lsad_pkg::OP_LFS, lsad_pkg::OP_LFSU, lsad_pkg::OP_STFS, lsad_pkg::OP_STFSU: begin
        r.is_access = 1'b1; r.ea = b + d16; r.nbytes = 8'd4;
      end
      lsad_pkg::OP_LBZ, lsad_pkg::OP_LBZU, lsad_pkg::OP_STB, lsad_pkg::OP_STBU: begin
        r.is_access = 1'b1; r.ea = b + d16; r.nbytes = 8'd1;
      end
      lsad_pkg::OP_LHZ, lsad_pkg::OP_LHZU, lsad_pkg::OP_LHA, lsad_pkg::OP_LHAU,
      lsad_pkg::OP_STH, lsad_pkg::OP_STHU: begin
        r.is_access = 1'b1; r.ea = b + d16; r.nbytes = 8'd2;
      end
      lsad_pkg::OP_LFD, lsad_pkg::OP_LFDU, lsad_pkg::OP_STFD, lsad_pkg::OP_STFDU: begin
        r.is_access = 1'b1; r.ea = b + d16; r.nbytes = 8'd8;
      end
      lsad_pkg::OP_LQ: begin
        r.is_access = 1'b1; r.ea = b + dq; r.nbytes = 8'd16;
      end
      lsad_pkg::OP_LMW, lsad_pkg::OP_STMW: begin
        r.is_access = 1'b1; r.ea = b + d16; r.nbytes = 8'(4 * (32 - rt));
      end
      default: ;
    endcase
    if (!r.is_access) begin
      r.ea = '0;
      r.nbytes = '0;
    end
    return r;
  endfunction

  function automatic logic [31:0] d_form(input logic [5:0] op, input logic [4:0] rt,
                                         input logic [4:0] ra, input logic [15:0] disp);
    return {op, rt, ra, disp};
  endfunction

  function automatic logic [31:0] x_form(input logic [9:0] xo, input logic [4:0] rt,
                                         input logic [4:0] ra, input logic [4:0] rb);
    return {lsad_pkg::OP_X31, rt, ra, rb, xo, 1'b0};
  endfunction

  // mostly known load/store forms with random fields, some raw noise
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    int          pick;
    w = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      w[31:26] = lsad_pkg::OP_X31;
      w[10:1] = known_xo[$urandom_range(known_xo.size() - 1, 0)];
    end else if (pick < 80) begin
      w[31:26] = MEM_OPS[$urandom_range($size(MEM_OPS) - 1, 0)];
    end else if (pick < 88) begin
      w[31:26] = lsad_pkg::OP_X31;
    end
    if ($urandom_range(7, 0) == 0) w[20:16] = 5'd0;
    return w;
  endfunction

  function automatic logic [63:0] random_register();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7, 0))
      0: v = '0;
      1: v = '1;
      // small top byte so the length forms land on both sides of the cap
      2, 3: v[63:56] = 8'($urandom_range(20, 0));
      default: ;
    endcase
    return v;
  endfunction

  // offer one request; starts and returns at a falling edge
  task automatic send_request(input logic [31:0] insn, input logic [63:0] base,
                              input logic [63:0] index);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= insn;
    in_base_value  <= base;
    in_index_value <= index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_accesses.push_back(decode_access(insn, base, index));
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(random_instruction(), random_register(), random_register());
  endtask

  task automatic wait_all_done();
    in_valid <= 1'b0;
    while (pending_accesses.size() != 0) @(negedge clk);
  endtask

  // displacement extremes, every form class and the odd cases
  task automatic test_directed_forms();
    send_request(d_form(lsad_pkg::OP_LWZ, 5'd3, 5'd1, 16'h7fff), 64'h1000, 64'h5);
    send_request(d_form(lsad_pkg::OP_LBZ, 5'd3, 5'd1, 16'h8000), 64'h0, 64'h0);
    // RA field zero ignores the base register
    send_request(d_form(lsad_pkg::OP_STH, 5'd0, 5'd0, 16'h0010), '1, '1);
    send_request(d_form(lsad_pkg::OP_LFD, 5'd31, 5'd31, 16'hffff), '1, 64'h0);
    // load/store multiple: from the whole register file down to one register
    send_request(d_form(lsad_pkg::OP_LMW, 5'd0, 5'd2, 16'h0004), 64'h2000, 64'h0);
    send_request(d_form(lsad_pkg::OP_STMW, 5'd31, 5'd2, 16'hfffc), 64'h2000, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS58, 5'd5, 5'd1, {14'h2000, DS58_LD}), 64'h10, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS58, 5'd5, 5'd1, {14'h1fff, DS58_LWA}), 64'h10, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS58, 5'd5, 5'd1, {14'h0001, DS58_RSVD}), 64'h10, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS57, 5'd6, 5'd7, {14'h3fff, DS57_LFDP}), 64'h40, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS57, 5'd6, 5'd7, {14'h0003, DS57_RSVD}), 64'h40, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS62, 5'd8, 5'd9, {14'h1234, DS62_STQ}), '1, 64'h0);
    send_request(d_form(lsad_pkg::OP_DS62, 5'd8, 5'd9, {14'h1234, DS62_RSVD}), '1, 64'h0);
    send_request(d_form(lsad_pkg::OP_LQ, 5'd4, 5'd1, {12'h800, 4'hf}), 64'h0, 64'h0);
    send_request(d_form(lsad_pkg::OP_DQ61, 5'd2, 5'd3, {12'h800, 1'b0, DQ61_LXV}), 64'h100,
                 64'h0);
    send_request(d_form(lsad_pkg::OP_DQ61, 5'd2, 5'd3, {13'h1fff, DQ61_STXV}), 64'h100, 64'h0);
    send_request(d_form(lsad_pkg::OP_DQ61, 5'd2, 5'd3, {14'h1555, SEL61_STXSD}), 64'h100,
                 64'h0);
    // length-in-RB forms: above, at and below the cap
    send_request(x_form(XO_LEN[0], 5'd1, 5'd4, 5'd5), 64'h8000_0000_0000_0003,
                 64'hff00_0000_0000_1234);
    send_request(x_form(XO_LEN[1], 5'd1, 5'd0, 5'd5), '1, 64'h1000_0000_0000_0000);
    send_request(x_form(XO_LEN[2], 5'd1, 5'd4, 5'd5), 64'h7, 64'h03ff_ffff_ffff_ffff);
    // cache block and full vector forms clear low address bits, cache block copy does not
    send_request(x_form(XO_LINE[6], 5'd0, 5'd3, 5'd4), 64'h0000_0000_0000_0fff, 64'h1);
    send_request(x_form(XO_MASK16[0], 5'd0, 5'd3, 5'd4), 64'h1234_5678_9abc_def1, 64'h6);
    send_request(x_form(XO_LINE_PLAIN[0], 5'd0, 5'd3, 5'd4), 64'h0fff, 64'h1);
    send_request(x_form(XO_UNSUP[0], 5'd2, 5'd3, 5'd4), 64'h100, 64'h200);
    send_request(x_form(XO_UNSUP[7], 5'd2, 5'd3, 5'd4), 64'h100, 64'h200);
    send_request(x_form(XO_CMP, 5'd2, 5'd3, 5'd4), 64'h100, 64'h200);
    send_request(d_form(OP_ILLEGAL, 5'd2, 5'd3, 16'h1234), 64'h100, 64'h200);
    send_request(x_form(XO_B8[0], 5'd1, 5'd0, 5'd2), '1, '1);
  endtask

  task automatic test_random_mix(input int count);
    send_idle_pct = 28;
    recv_idle_pct = 28;
    send_random(count);
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(count);
    send_idle_pct = 28;
    recv_idle_pct = 28;
  endtask

  // receiver holds off while requests keep coming so the input stalls
  task automatic test_output_backpressure();
    wait_all_done();
    send_idle_pct = 0;
    stall_hold = HOLD_OFF_CYCLES;
    send_random(40);
    send_idle_pct = 28;
  endtask

  // bursts separated by a full drain of the pipeline
  task automatic test_pause_and_resume();
    repeat (4) begin
      send_random(30);
      wait_all_done();
    end
  endtask

  // receiver stall generation
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result with the oldest pending request
  always @(posedge clk) begin : result_check
    access_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_accesses.size() == 0) begin
        $display("%0t: result with no request pending, expected none got ea %h",
                 $time, out_effective_address);
        error_count++;
      end else begin
        want = pending_accesses.pop_front();
        check_field("is_access", 64'(want.is_access), 64'(out_is_access));
        check_field("unsupported", 64'(want.unsupported), 64'(out_unsupported));
        check_field("effective_address", want.ea, out_effective_address);
        check_field("access_bytes", 64'(want.nbytes), 64'(out_access_bytes));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_xo_tables();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_forms();
    test_random_mix(600);
    test_back_to_back(300);
    test_output_backpressure();
    test_pause_and_resume();
    test_random_mix(360);
    wait_all_done();
    repeat (4) @(negedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
